// ----- hdl/btr_pkg.sv -----
// shared types, constants and glyph lookup for the bitmap text renderer
package btr_pkg;

  localparam int unsigned GlyphCount = 41;
  localparam int unsigned RowCount   = 10;
  localparam int unsigned MaskBits   = 12;

  localparam logic [7:0] CodeNewline = 8'd10;
  localparam logic [7:0] CodeSpace   = 8'd32;

  localparam logic [3:0] LineStep   = 4'd10;
  localparam logic [3:0] SpaceStep  = 4'd9;
  localparam logic [3:0] WrapMargin = 4'd12;
  localparam logic [9:0] YMax       = 10'd1023;

  localparam logic [1:0] RegOriginX = 2'd0;
  localparam logic [1:0] RegOriginY = 2'd1;
  localparam logic [1:0] RegInk     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ROWS,
    ST_DONE
  } state_t;

  // glyph descriptor from the code lookup
  typedef struct packed {
    logic       found;
    logic [5:0] index;
    logic [3:0] width;
    logic [3:0] height;
  } glyph_info_t;

  // saturating add for the y cursor
  function automatic logic [9:0] add_sat_y(input logic [9:0] y, input logic [3:0] d);
    logic [10:0] s;
    s = {1'b0, y} + {7'd0, d};
    return (s > {1'b0, YMax}) ? YMax : s[9:0];
  endfunction

  // code to glyph index, width and height
  function automatic glyph_info_t glyph_lookup(input logic [7:0] code);
    glyph_info_t g;
    g = '{found: 1'b1, index: 6'd0, width: 4'd0, height: 4'd8};
    case (code)
      8'h41: begin g.index = 6'd0;  g.width = 4'd8;  end
      8'h42: begin g.index = 6'd1;  g.width = 4'd7;  end
      8'h43: begin g.index = 6'd2;  g.width = 4'd7;  end
      8'h44: begin g.index = 6'd3;  g.width = 4'd8;  end
      8'h45: begin g.index = 6'd4;  g.width = 4'd7;  end
      8'h46: begin g.index = 6'd5;  g.width = 4'd7;  end
      8'h47: begin g.index = 6'd6;  g.width = 4'd8;  end
      8'h48: begin g.index = 6'd7;  g.width = 4'd9;  end
      8'h49: begin g.index = 6'd8;  g.width = 4'd4;  end
      8'h4A: begin g.index = 6'd9;  g.width = 4'd6;  end
      8'h4B: begin g.index = 6'd10; g.width = 4'd8;  end
      8'h4C: begin g.index = 6'd11; g.width = 4'd7;  end
      8'h4D: begin g.index = 6'd12; g.width = 4'd10; end
      8'h4E: begin g.index = 6'd13; g.width = 4'd8;  end
      8'h4F: begin g.index = 6'd14; g.width = 4'd8;  end
      8'h50: begin g.index = 6'd15; g.width = 4'd7;  end
      8'h51: begin g.index = 6'd16; g.width = 4'd8;  g.height = 4'd10; end
      8'h52: begin g.index = 6'd17; g.width = 4'd9;  end
      8'h53: begin g.index = 6'd18; g.width = 4'd5;  end
      8'h54: begin g.index = 6'd19; g.width = 4'd8;  end
      8'h55: begin g.index = 6'd20; g.width = 4'd8;  end
      8'h56: begin g.index = 6'd21; g.width = 4'd8;  end
      8'h57: begin g.index = 6'd22; g.width = 4'd12; end
      8'h58: begin g.index = 6'd23; g.width = 4'd7;  end
      8'h59: begin g.index = 6'd24; g.width = 4'd8;  end
      8'h5A: begin g.index = 6'd25; g.width = 4'd7;  end
      8'h30: begin g.index = 6'd26; g.width = 4'd5;  end
      8'h31: begin g.index = 6'd27; g.width = 4'd4;  end
      8'h32: begin g.index = 6'd28; g.width = 4'd5;  end
      8'h33: begin g.index = 6'd29; g.width = 4'd5;  end
      8'h34: begin g.index = 6'd30; g.width = 4'd6;  end
      8'h35: begin g.index = 6'd31; g.width = 4'd5;  end
      8'h36: begin g.index = 6'd32; g.width = 4'd5;  end
      8'h37: begin g.index = 6'd33; g.width = 4'd5;  end
      8'h38: begin g.index = 6'd34; g.width = 4'd5;  end
      8'h39: begin g.index = 6'd35; g.width = 4'd5;  end
      8'h2E: begin g.index = 6'd36; g.width = 4'd2;  end
      8'h2C: begin g.index = 6'd37; g.width = 4'd2;  g.height = 4'd10; end
      8'h3A: begin g.index = 6'd38; g.width = 4'd2;  end
      8'h3D: begin g.index = 6'd39; g.width = 4'd4;  end
      8'h25: begin g.index = 6'd40; g.width = 4'd8;  end
      default: begin g.found = 1'b0; end
    endcase
    return g;
  endfunction

endpackage

// ----- hdl/bitmap_text_renderer.sv -----
// bitmap text renderer top level
// code is registered, looked up in ST_LOOK, which registers the first row beat
// one glyph row per cycle unless out_ready stalls, set by the row rom port; a new
//   character is taken in ST_IDLE only; newline, space, unknown codes give no rows
// reset: cursor to 0,0, origins 0, ink 25700, no beat pending
module bitmap_text_renderer
  import btr_pkg::*;
#(
  parameter int unsigned SCREEN_COLUMNS = 320
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        first_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  row_y,
  output logic [9:0]  col_x,
  output logic [11:0] pixel_mask,
  output logic [3:0]  glyph_width,
  output logic [15:0] pixel_color,
  output logic        last_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [11:0] ScreenCols = 12'(SCREEN_COLUMNS);

  logic [9:0]  origin_x, origin_y;
  logic [15:0] ink_value;
  state_t      state, state_next;

  logic [7:0]  code;
  logic        first;
  glyph_info_t ginfo;
  logic [9:0]  cur_x, cur_y;
  logic [3:0]  row;
  logic        rom_en;
  logic [11:0] rom_mask;
  logic        cur_we;
  logic [19:0] cur_wdata, cur_rdata;
  logic [9:0]  base_x, base_y, new_y;
  logic [11:0] adv_x, adv_plus;
  logic        out_hold;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      ink_value <= 16'd25700;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegOriginX: origin_x  <= cfg_data[9:0];
        RegOriginY: origin_y  <= cfg_data[9:0];
        RegInk:     ink_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // accepted character
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code  <= char_code;
      first <= first_of_text;
    end
  end

  btr_cursor_ram u_cur (
    .clk(clk), .rst(rst), .we(cur_we), .wdata(cur_wdata), .rdata(cur_rdata)
  );

  // cursor after optional reload
  always_comb begin
    base_x = first ? origin_x : cur_rdata[9:0];
    base_y = first ? origin_y : cur_rdata[19:10];
    ginfo  = glyph_lookup(code);
  end

  // latch cursor for the row phase
  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      cur_x <= base_x;
      cur_y <= base_y;
    end
  end

  // row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (state == ST_LOOK) begin
      row <= 4'd1;
    end else if (rom_en && state == ST_ROWS) begin
      row <= row + 4'd1;
    end
  end

  btr_font_rom u_rom (
    .clk(clk), .rd_en(rom_en), .glyph(ginfo.index),
    .row((state == ST_LOOK) ? 4'd0 : row), .mask(rom_mask)
  );

  // next cursor
  always_comb begin
    new_y = base_y;
    if (code == CodeNewline) begin
      adv_x = {2'b0, origin_x};
      new_y = add_sat_y(base_y, LineStep);
    end else if (code == CodeSpace) begin
      adv_x = {2'b0, base_x} + {8'd0, SpaceStep};
    end else if (ginfo.found) begin
      adv_x = {2'b0, base_x} + {8'd0, ginfo.width} + 12'd1;
    end else begin
      adv_x = {2'b0, base_x} + 12'd1;
    end
    adv_plus  = adv_x + {8'd0, WrapMargin};
    cur_wdata = (adv_plus >= ScreenCols) ? {add_sat_y(new_y, LineStep), 10'd0}
                                         : {new_y, adv_x[9:0]};
    cur_we    = (state == ST_LOOK);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rom_en && state == ST_ROWS) begin
      out_valid <= 1'b1;
    end else if (rom_en && state == ST_LOOK && ginfo.found && code != CodeNewline
                 && code != CodeSpace) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rom_en) begin
      row_y       <= add_sat_y((state == ST_LOOK) ? base_y : cur_y,
                               (state == ST_LOOK) ? 4'd0 : row);
      col_x       <= (state == ST_LOOK) ? base_x : cur_x;
      glyph_width <= ginfo.width;
      pixel_color <= ink_value;
      last_row    <= ((state == ST_LOOK) ? 4'd1 : row + 4'd1) == ginfo.height;
    end
  end
  assign pixel_mask = rom_mask;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_LOOK;
      ST_LOOK: begin
        if (ginfo.found && code != CodeNewline && code != CodeSpace && ginfo.height != 4'd1)
          state_next = ST_ROWS;
        else if (ginfo.found && code != CodeNewline && code != CodeSpace)
          state_next = ST_DONE;
        else
          state_next = ST_IDLE;
      end
      ST_ROWS: if (rom_en && row + 4'd1 == ginfo.height) state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    out_hold = out_valid && !out_ready;
    case (state)
      ST_LOOK: rom_en = 1'b1;
      ST_ROWS: rom_en = !out_hold;
      default: rom_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/btr_font_rom.sv -----
// synchronous glyph row rom, one row mask per read
module btr_font_rom
  import btr_pkg::*;
(
  input  logic        clk,
  input  logic        rd_en,
  input  logic [5:0]  glyph,
  input  logic [3:0]  row,
  output logic [11:0] mask
);

  // row mask bit i is column i; rows past the glyph height are zero
  function automatic logic [11:0] pat(input string s, input int w, input int r);
    logic [11:0] m;
    m = '0;
    for (int c = 0; c < 12; c++) begin
      if (c < w && (r * w + c) < s.len()) begin
        if (s[r * w + c] == "#") begin
          m[c] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  function automatic logic [11:0] rom_row(input logic [5:0] g, input logic [3:0] r);
    int ri;
    ri = int'(r);
    case (g)
      6'd0:  return pat("...##......##......###....#.##....####...#...##..#...##.###.####", 8, ri);
      6'd1:  return pat("######..##..##.##..##.#####..##..##.##..##.##..#######.", 7, ri);
      6'd2:  return pat("..###.#.##..####....###.....##.....##......##...#..####.", 7, ri);
      6'd3:  return pat("######...##..##..##...##.##...##.##...##.##...##.##..##.######..", 8, ri);
      6'd4:  return pat("#######.##..##.##.#.#.####...##.#...##...#.##..########", 7, ri);
      6'd5:  return pat("#######.##..##.##.#.#.####...##.#...##.....##.....####...", 7, ri);
      6'd6:  return pat("..###.#..##..##.##....#.##......##......##..####.##..##...####..", 8, ri);
      6'd7:  return pat({"####.####.##...##..##...##..#######..##...##..##...##..##...##",
                         ".####.####"}, 9, ri);
      6'd8:  return pat("####.##..##..##..##..##..##.####", 4, ri);
      6'd9:  return pat("..####...##....##....##....##.##.##.##.##..###..", 6, ri);
      6'd10: return pat("####.###.##..#...##.#....####....####....##.##...##..##.####.###", 8, ri);
      6'd11: return pat("####....##.....##.....##.....##.....##...#.##..########", 7, ri);
      6'd12: return pat({"####..####.###..###..###..###..#.###.##..#.###.##..#.###.##..#",
                         "..#..##.###.#.####"}, 10, ri);
      6'd13: return pat("###..###.###..#..#.##.#..#.##.#..#..###..#...##..#...##.###...##", 8, ri);
      6'd14: return pat("..####...##..##.##....####....####....####....##.##..##...####..", 8, ri);
      6'd15: return pat("######..##..##.##..##.##..##.#####..##.....##.....####...", 7, ri);
      6'd16: return pat({"..####...##..##.##....####....####....####....##.##..##...####",
                         ".....##.......####"}, 8, ri);
      6'd17: return pat({"######....##..##...##..##...#####....##..##...##..##...##...##",
                         ".####..###"}, 9, ri);
      6'd18: return pat(".##.###.####...####..####...####.###.##.", 5, ri);
      6'd19: return pat("##########.##.###..##..#...##......##......##......##.....####..", 8, ri);
      6'd20: return pat("####.###.##...#..##...#..##...#..##...#..##...#..##...#...####..", 8, ri);
      6'd21: return pat("####.###.##...#..##...#...##.#....##.#....##.#.....##......##...", 8, ri);
      6'd22: return pat({"###.####.###.##..##...#..##...#..#....##.###.#....##.###.#.....",
                         "##..##......##..##......##..##..."}, 12, ri);
      6'd23: return pat("####.##.##..#...###....##.......##....###...#..##.##..###", 7, ri);
      6'd24: return pat("####.###.##...#...##.#....##.#.....##......##......##.....####..", 8, ri);
      6'd25: return pat("########..##.#..##.....##.....##.....##..#.##..########", 7, ri);
      6'd26: return pat(".###.##.####.####.####.####.####.##.###.", 5, ri);
      6'd27: return pat("###..##..##..##..##..##..##.####", 4, ri);
      6'd28: return pat(".###.#######..##...#....#..##...#########", 5, ri);
      6'd29: return pat(".###.#..##...##..##....##...###..##.###.", 5, ri);
      6'd30: return pat("....#....##...#.#..#..#.#...#.######...##....##.", 6, ri);
      6'd31: return pat(".####.###..#...####.#####....###.#.###..", 5, ri);
      6'd32: return pat("...##.##...#...####.##.####.####.##.###.", 5, ri);
      6'd33: return pat("#########....#....#....#....#...#....#..", 5, ri);
      6'd34: return pat(".###.##.####.##.###..###.##.####.##.###.", 5, ri);
      6'd35: return pat(".###.##.####.####.##.####...#...##.##...", 5, ri);
      6'd36: return pat("............####", 2, ri);
      6'd37: return pat("............####.##.", 2, ri);
      6'd38: return pat("....####..####..", 2, ri);
      6'd39: return pat("............####....####........", 4, ri);
      6'd40: return pat(".#....#.#.#..#..#.#.#...#.#.#.#..#.#.#.#...#.#.#..#..#.#.#....#.", 8, ri);
      default: return 12'd0;
    endcase
  endfunction

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mask <= rom_row(glyph, row);
    end
  end

endmodule

// ----- hdl/btr_cursor_ram.sv -----
// one-entry synchronous cursor memory with write-through forwarding
module btr_cursor_ram (
  input  logic        clk,
  input  logic        rst,
  input  logic        we,
  input  logic [19:0] wdata,
  output logic [19:0] rdata
);

  logic [19:0] mem [1];
  logic        written;

  // cursor state {y, x}
  always_ff @(posedge clk) begin
    if (we) begin
      mem[0] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= 1'b0;
    end else if (we) begin
      written <= 1'b1;
    end
  end

  // registered read, a same-cycle write is forwarded; zero until first write
  always_ff @(posedge clk) begin
    if (rst) begin
      rdata <= '0;
    end else if (we) begin
      rdata <= wdata;
    end else if (written) begin
      rdata <= mem[0];
    end else begin
      rdata <= '0;
    end
  end

endmodule

// ----- hdl/btr_checker.sv -----
// port-level checks for the bitmap text renderer
module btr_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  row_y,
  input logic [3:0]  glyph_width,
  input logic        last_row
);

  // output beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_y))
    else $error("output beat changed while stalled");

  // no new character while rows are pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_row |-> !in_ready)
    else $error("character accepted mid glyph");

  // width is never zero on a beat
  a_width: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> glyph_width != 4'd0)
    else $error("zero glyph width");

  // beats follow an accepted character
  a_first: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid || !in_ready)
    else $error("unexpected output after accept");

endmodule

bind bitmap_text_renderer btr_port_checks u_btr_port_checks (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .row_y(row_y),
  .glyph_width(glyph_width), .last_row(last_row)
);
